/* hdl/dwr_pkg.sv */
// ----------------------------------------------------------------------------
// dwr_pkg: shared types and constants
// Fixed field widths, codes and the records that travel between the stages
// of the decimated waveform RMS block.
// ----------------------------------------------------------------------------
package dwr_pkg;

  localparam int LEN_W       = 7;
  localparam int MEAN_FRAC   = 8;
  localparam int DIV_STEPS   = 8;
  localparam int RMS_W       = 23;
  localparam int CNT_OUT_W   = 11;
  localparam int OUT_TDATA_W = 40;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LEN_W-1:0] MAX_LEN   = 7'd64;
  localparam logic [LEN_W-1:0] RESET_LEN = 7'd15;
  localparam logic [RMS_W-1:0] RMS_MAX   = 23'h7FFFFF;

  // Classification of one queued transaction from the front end.
  typedef struct packed {
    logic             has_block;
    logic             last;
    logic             neg;
    logic [LEN_W-1:0] len;
  } dwr_tag_t;

  // Request from the accumulator stage to the end-of-waveform sequencer.
  typedef struct packed {
    logic start;
    logic overflow;
  } dwr_fin_req_t;

  // Result flags, no_blocks in the lowest bit.
  typedef struct packed {
    logic block_overflow;
    logic no_blocks;
  } dwr_flags_t;

endpackage

/* hdl/dwr_front.sv */
// ----------------------------------------------------------------------------
// dwr_front: sample intake and block classification
// Sums samples into the current block, detects block completion and the end
// of the waveform, and pushes one queue entry per sample that marks either.
// ----------------------------------------------------------------------------
module dwr_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dwr_pkg::LEN_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                last_i,
  output logic                                in_ready_o,
  input  logic                                q_full_i,
  output logic                                push_o,
  output dwr_pkg::dwr_tag_t                   tag_o,
  output logic [SAMPLE_BITS+5:0]              mag_o
);

  localparam int BSW = SAMPLE_BITS + 6;

  logic [dwr_pkg::LEN_W-1:0] block_length_q;
  logic signed [BSW-1:0]     block_sum_q;
  logic [dwr_pkg::LEN_W-1:0] block_pos_q;

  logic [dwr_pkg::LEN_W-1:0] eff_len;
  logic signed [BSW-1:0]     sum_d;
  logic [dwr_pkg::LEN_W-1:0] pos_d;
  logic                      done;
  logic                      accept;

  always_comb begin
    priority if (block_length_q == '0) begin
      eff_len = dwr_pkg::LEN_W'(1);
    end else if (block_length_q > dwr_pkg::MAX_LEN) begin
      eff_len = dwr_pkg::MAX_LEN;
    end else begin
      eff_len = block_length_q;
    end
  end

  assign sum_d      = block_sum_q + BSW'(sample_i);
  assign pos_d      = block_pos_q + 1'b1;
  assign done       = (pos_d >= eff_len);
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (done || last_i);

  // The most negative block sum negates to its own bit pattern, which is the
  // correct unsigned magnitude.
  assign mag_o           = sum_d[BSW-1] ? BSW'(-sum_d) : BSW'(sum_d);
  assign tag_o.has_block = done;
  assign tag_o.last      = last_i;
  assign tag_o.neg       = sum_d[BSW-1];
  assign tag_o.len       = eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= dwr_pkg::RESET_LEN;
      block_sum_q    <= '0;
      block_pos_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        block_length_q <= cfg_wdata_i;
      end
      if (accept) begin
        // A trailing partial block is dropped at the end of the waveform.
        if (done || last_i) begin
          block_sum_q <= '0;
          block_pos_q <= '0;
        end else begin
          block_sum_q <= sum_d;
          block_pos_q <= pos_d;
        end
      end
    end
  end

endmodule

/* hdl/dwr_queue.sv */
// ----------------------------------------------------------------------------
// dwr_queue: small register queue
// Decouples the sample front end from the accumulator stage.
// ----------------------------------------------------------------------------
module dwr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [CW-1:0]    count_q;

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/dwr_back.sv */
// ----------------------------------------------------------------------------
// dwr_back: block mean and waveform accumulators
// Divides each block sum by the block length, squares the mean and keeps the
// count, the sum of means and the sum of squares until the waveform ends.
// ----------------------------------------------------------------------------
module dwr_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_BLOCKS  = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_empty_i,
  input  dwr_pkg::dwr_tag_t                     tag_i,
  input  logic [SAMPLE_BITS+5:0]                mag_i,
  output logic                                  pop_o,
  input  logic                                  fin_busy_i,
  output dwr_pkg::dwr_fin_req_t                 fin_req_o,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]       n_o,
  output logic signed [SAMPLE_BITS+7+$clog2(MAX_BLOCKS+1):0] s1_o,
  output logic [2*SAMPLE_BITS+13+$clog2(MAX_BLOCKS+1):0]     s2_o
);

  localparam int MAG_W   = SAMPLE_BITS + 6;
  localparam int XW      = MAG_W + dwr_pkg::MEAN_FRAC;
  localparam int DIV_CYC = (XW + dwr_pkg::DIV_STEPS - 1) / dwr_pkg::DIV_STEPS;
  localparam int XPW     = DIV_CYC * dwr_pkg::DIV_STEPS;
  localparam int QW      = SAMPLE_BITS + 8;
  localparam int NW      = $clog2(MAX_BLOCKS + 1);
  localparam int S1W     = SAMPLE_BITS + 8 + NW;
  localparam int S2W     = 2 * SAMPLE_BITS + 14 + NW;
  localparam int CW      = $clog2(DIV_CYC);
  localparam int LW      = dwr_pkg::LEN_W;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_SQR,
    B_ACC,
    B_FIN
  } back_state_e;

  back_state_e           state_q;
  dwr_pkg::dwr_tag_t     tag_q;
  logic [XPW-1:0]        dvd_q;
  logic [XPW-1:0]        quo_q;
  logic [LW-1:0]         rem_q;
  logic [CW-1:0]         cnt_q;
  logic [2*QW-1:0]       sq_q;
  logic [NW-1:0]         total_q;
  logic signed [S1W-1:0] s1_q;
  logic [S2W-1:0]        s2_q;
  logic                  ovf_q;

  logic [XPW-1:0]        dvd_d;
  logic [XPW-1:0]        quo_d;
  logic [LW-1:0]         rem_d;
  logic [QW-1:0]         mean_mag;
  logic signed [S1W-1:0] mean_ext;
  logic                  start;

  // Restoring division by the block length, several quotient bits a cycle.
  // The remainder stays below the length, so each step is a narrow compare.
  always_comb begin
    logic [LW:0] t;
    logic        ge;
    dvd_d = dvd_q;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < dwr_pkg::DIV_STEPS; i++) begin
      t     = {rem_d, dvd_d[XPW-1]};
      dvd_d = {dvd_d[XPW-2:0], 1'b0};
      ge    = (t >= {1'b0, tag_q.len});
      if (ge) begin
        t = t - {1'b0, tag_q.len};
      end
      quo_d = {quo_d[XPW-2:0], ge};
      rem_d = t[LW-1:0];
    end
  end

  assign mean_mag = quo_q[QW-1:0];
  assign mean_ext = $signed(S1W'(mean_mag));
  assign pop_o    = (state_q == B_IDLE) && !q_empty_i;
  assign start    = (state_q == B_FIN) && !fin_busy_i;

  assign fin_req_o.start    = start;
  assign fin_req_o.overflow = ovf_q;
  assign n_o                = total_q;
  assign s1_o               = s1_q;
  assign s2_o               = s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      total_q <= '0;
      s1_q    <= '0;
      s2_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            state_q <= tag_i.has_block ? B_DIV : B_FIN;
          end
        end
        B_DIV: begin
          if (cnt_q == '0) begin
            state_q <= B_SQR;
          end
        end
        B_SQR: begin
          state_q <= B_ACC;
        end
        B_ACC: begin
          if (total_q == NW'(MAX_BLOCKS)) begin
            ovf_q <= 1'b1;
          end else begin
            total_q <= total_q + 1'b1;
            s1_q    <= tag_q.neg ? s1_q - mean_ext : s1_q + mean_ext;
            s2_q    <= s2_q + S2W'(sq_q);
          end
          state_q <= tag_q.last ? B_FIN : B_IDLE;
        end
        B_FIN: begin
          // The sequencer takes a snapshot, so the next waveform can start.
          if (start) begin
            total_q <= '0;
            s1_q    <= '0;
            s2_q    <= '0;
            ovf_q   <= 1'b0;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tag_q <= tag_i;
      dvd_q <= XPW'({mag_i, {dwr_pkg::MEAN_FRAC{1'b0}}});
      quo_q <= '0;
      rem_q <= '0;
      cnt_q <= CW'(DIV_CYC - 1);
    end else if (state_q == B_DIV) begin
      dvd_q <= dvd_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q - 1'b1;
    end
    if (state_q == B_SQR) begin
      sq_q <= mean_mag * mean_mag;
    end
  end

endmodule

/* hdl/dwr_final.sv */
// ----------------------------------------------------------------------------
// dwr_final: end-of-waveform sequencer
// Forms N*S2 - S1^2 by shift and add, divides it by N^2 one bit a cycle,
// takes the integer square root two bits a cycle and holds the result.
// ----------------------------------------------------------------------------
module dwr_final #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_BLOCKS  = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dwr_pkg::dwr_fin_req_t                 req_i,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0]       n_i,
  input  logic signed [SAMPLE_BITS+7+$clog2(MAX_BLOCKS+1):0] s1_i,
  input  logic [2*SAMPLE_BITS+13+$clog2(MAX_BLOCKS+1):0]     s2_i,
  output logic                                  busy_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [dwr_pkg::RMS_W-1:0]             rms_o,
  output logic [dwr_pkg::CNT_OUT_W-1:0]         blocks_o,
  output dwr_pkg::dwr_flags_t                   flags_o
);

  localparam int NW   = $clog2(MAX_BLOCKS + 1);
  localparam int S1W  = SAMPLE_BITS + 8 + NW;
  localparam int S2W  = 2 * SAMPLE_BITS + 14 + NW;
  localparam int M1W  = S1W - 1;
  localparam int DW   = S2W + NW + 1;
  localparam int DQ   = DW - 1;
  localparam int VW   = 2 * SAMPLE_BITS + 15;
  localparam int SW   = (VW + 1) / 2;
  localparam int EW   = 2 * SW;
  localparam int CNTW = $clog2(DQ);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MULA,
    F_MULB,
    F_CHK,
    F_DIV,
    F_SQRT,
    F_OUT
  } fin_state_e;

  fin_state_e            state_q;
  logic [CNTW-1:0]       cnt_q;
  logic [NW-1:0]         n_q;
  logic                  ovf_q;
  logic [DW-1:0]         mcand_q;
  logic [M1W-1:0]        mplr_q;
  logic [M1W-1:0]        m1_q;
  logic signed [DW-1:0]  acc_q;
  logic [2*NW-1:0]       nsq_q;
  logic [DQ-1:0]         dvd_q;
  logic [2*NW-1:0]       rem_q;
  logic [VW-1:0]         var_q;
  logic [EW-1:0]         v_q;
  logic [EW-1:0]         res_q;
  logic [EW-1:0]         bit_q;
  logic [dwr_pkg::RMS_W-1:0]     rms_q;
  logic [dwr_pkg::CNT_OUT_W-1:0] blocks_q;
  dwr_pkg::dwr_flags_t           flags_q;

  logic signed [S1W-1:0] s1_abs;
  logic [2*NW:0]         dt;
  logic                  dge;
  logic [2*NW:0]         dt_sub;
  logic [VW-1:0]         var_d;
  logic [EW-1:0]         sq_sum;
  logic                  sge;
  logic [EW-1:0]         res_d;

  assign s1_abs = s1_i[S1W-1] ? -s1_i : s1_i;

  assign dt     = {rem_q, dvd_q[DQ-1]};
  assign dge    = (dt >= {1'b0, nsq_q});
  assign dt_sub = dge ? dt - {1'b0, nsq_q} : dt;
  assign var_d  = {var_q[VW-2:0], dge};

  assign sq_sum = res_q + bit_q;
  assign sge    = (v_q >= sq_sum);
  assign res_d  = sge ? (res_q >> 1) + bit_q : (res_q >> 1);

  assign busy_o      = (state_q != F_IDLE);
  assign out_valid_o = (state_q == F_OUT);
  assign rms_o       = rms_q;
  assign blocks_o    = blocks_q;
  assign flags_o     = flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      rms_q    <= '0;
      blocks_q <= '0;
      flags_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (req_i.start) begin
            state_q <= F_MULA;
          end
        end
        F_MULA: begin
          if (cnt_q == '0) begin
            state_q <= F_MULB;
          end
        end
        F_MULB: begin
          if (cnt_q == '0) begin
            state_q <= F_CHK;
          end
        end
        F_CHK: begin
          blocks_q                <= dwr_pkg::CNT_OUT_W'(n_q);
          flags_q.no_blocks       <= (n_q == '0);
          flags_q.block_overflow  <= ovf_q;
          // A variance numerator of zero or below gives a zero result.
          if (acc_q <= 0) begin
            rms_q   <= '0;
            state_q <= F_OUT;
          end else begin
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          if (cnt_q == '0) begin
            state_q <= F_SQRT;
          end
        end
        F_SQRT: begin
          if (cnt_q == '0) begin
            rms_q   <= (res_d > EW'(dwr_pkg::RMS_MAX)) ? dwr_pkg::RMS_MAX
                                                       : res_d[dwr_pkg::RMS_W-1:0];
            state_q <= F_OUT;
          end
        end
        F_OUT: begin
          if (out_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        n_q     <= n_i;
        ovf_q   <= req_i.overflow;
        mcand_q <= DW'(s2_i);
        mplr_q  <= M1W'(n_i);
        m1_q    <= s1_abs[M1W-1:0];
        acc_q   <= '0;
        nsq_q   <= n_i * n_i;
        cnt_q   <= CNTW'(NW - 1);
      end
      F_MULA: begin
        if (mplr_q[0]) begin
          acc_q <= acc_q + $signed(mcand_q);
        end
        if (cnt_q == '0) begin
          mcand_q <= DW'(m1_q);
          mplr_q  <= m1_q;
          cnt_q   <= CNTW'(M1W - 1);
        end else begin
          mcand_q <= {mcand_q[DW-2:0], 1'b0};
          mplr_q  <= mplr_q >> 1;
          cnt_q   <= cnt_q - 1'b1;
        end
      end
      F_MULB: begin
        if (mplr_q[0]) begin
          acc_q <= acc_q - $signed(mcand_q);
        end
        mcand_q <= {mcand_q[DW-2:0], 1'b0};
        mplr_q  <= mplr_q >> 1;
        cnt_q   <= cnt_q - 1'b1;
      end
      F_CHK: begin
        dvd_q <= acc_q[DQ-1:0];
        rem_q <= '0;
        var_q <= '0;
        cnt_q <= CNTW'(DQ - 1);
      end
      F_DIV: begin
        rem_q <= dt_sub[2*NW-1:0];
        dvd_q <= {dvd_q[DQ-2:0], 1'b0};
        var_q <= var_d;
        if (cnt_q == '0) begin
          v_q   <= EW'(var_d);
          res_q <= '0;
          bit_q <= {2'b01, {(EW-2){1'b0}}};
          cnt_q <= CNTW'(SW - 1);
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      F_SQRT: begin
        if (sge) begin
          v_q <= v_q - sq_sum;
        end
        res_q <= res_d;
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q - 1'b1;
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

endmodule

/* hdl/decimated_waveform_rms.sv */
// ----------------------------------------------------------------------------
// decimated_waveform_rms: RMS of boxcar-decimated waveform samples
// Averages samples in blocks of a configured length and reports the RMS of
// the block means about their average, in Q.8, at the end of each waveform.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata: sample; tlast: last_sample
//  m_axis    out        tvalid/tready          tdata: rms_value, blocks_used;
//                                              tuser: no_blocks, block_overflow
//  cfg       in         cfg_we_i               cfg_wdata_i: block_length
//
// Samples are taken one per cycle while the four-entry queue has room. Each
// completed block passes through the accumulator stage's pop, divide, square
// and accumulate steps (divider at eight quotient bits a cycle), while the
// queue keeps taking samples as long as it has room. The end of a waveform
// runs the sequencer's bit-serial multiply, divide and square root; the next
// waveform's blocks keep accumulating meanwhile. No clearing pass after
// reset. A stalled result holds the sequencer, and then the queue backs up.
//
module decimated_waveform_rms #(
  parameter int MAX_BLOCKS  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dwr_pkg::LEN_W-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [SAMPLE_BITS-1:0] sample, zero padding above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [22:0] rms_value, [33:23] blocks_used, zero padding above
  output logic [dwr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // [0] no_blocks, [1] block_overflow
  output dwr_pkg::dwr_flags_t               m_axis_tuser_o
);

  localparam int MAG_W = SAMPLE_BITS + 6;
  localparam int QDW   = $bits(dwr_pkg::dwr_tag_t) + MAG_W;
  localparam int NW    = $clog2(MAX_BLOCKS + 1);
  localparam int S1W   = SAMPLE_BITS + 8 + NW;
  localparam int S2W   = 2 * SAMPLE_BITS + 14 + NW;
  localparam int PADW  = dwr_pkg::OUT_TDATA_W - dwr_pkg::RMS_W - dwr_pkg::CNT_OUT_W;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          push;
  dwr_pkg::dwr_tag_t             push_tag;
  logic [MAG_W-1:0]              push_mag;
  logic [QDW-1:0]                q_rdata;
  logic                          q_full;
  logic                          q_empty;
  logic                          pop;
  dwr_pkg::dwr_tag_t             pop_tag;
  logic [MAG_W-1:0]              pop_mag;
  dwr_pkg::dwr_fin_req_t         fin_req;
  logic                          fin_busy;
  logic [NW-1:0]                 n_tot;
  logic signed [S1W-1:0]         s1;
  logic [S2W-1:0]                s2;
  logic [dwr_pkg::RMS_W-1:0]     rms;
  logic [dwr_pkg::CNT_OUT_W-1:0] blocks;

  assign sample = $signed(s_axis_tdata_i[SAMPLE_BITS-1:0]);
  assign {pop_tag, pop_mag} = q_rdata;

  dwr_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .sample_i    (sample),
    .last_i      (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .tag_o       (push_tag),
    .mag_o       (push_mag)
  );

  dwr_queue #(
    .WIDTH(QDW),
    .DEPTH(dwr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_tag, push_mag}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  dwr_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .tag_i      (pop_tag),
    .mag_i      (pop_mag),
    .pop_o      (pop),
    .fin_busy_i (fin_busy),
    .fin_req_o  (fin_req),
    .n_o        (n_tot),
    .s1_o       (s1),
    .s2_o       (s2)
  );

  dwr_final #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (fin_req),
    .n_i         (n_tot),
    .s1_i        (s1),
    .s2_i        (s2),
    .busy_o      (fin_busy),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .rms_o       (rms),
    .blocks_o    (blocks),
    .flags_o     (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{PADW{1'b0}}, blocks, rms};

endmodule

/* hdl/dwr_checker.sv */
// ----------------------------------------------------------------------------
// dwr_checker: port-level checks for decimated_waveform_rms
// Watches the result channel for handshake and result consistency.
// ----------------------------------------------------------------------------
module dwr_checker #(
  parameter int MAX_BLOCKS = 1024
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [dwr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input dwr_pkg::dwr_flags_t             m_axis_tuser_o
);

  localparam int CNT_LO = dwr_pkg::RMS_W;
  localparam int CNT_HI = dwr_pkg::RMS_W + dwr_pkg::CNT_OUT_W - 1;

  // No result is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result offered during reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result withdrawn before transaction");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // An empty waveform reports a zero RMS and a zero block count.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o.no_blocks |->
      (m_axis_tdata_o[dwr_pkg::RMS_W-1:0] == '0) && (m_axis_tdata_o[CNT_HI:CNT_LO] == '0))
    else $error("empty waveform with nonzero result");

  // Blocks are only dropped once the count has reached capacity.
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o.block_overflow |->
      (m_axis_tdata_o[CNT_HI:CNT_LO] == dwr_pkg::CNT_OUT_W'(MAX_BLOCKS)))
    else $error("overflow flagged below capacity");

endmodule

bind decimated_waveform_rms dwr_checker #(
  .MAX_BLOCKS(MAX_BLOCKS)
) u_dwr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* tb/tb_decimated_waveform_rms.sv */
// ----------------------------------------------------------------------------
// tb_decimated_waveform_rms: self-checking testbench for decimated_waveform_rms
// Streams signed samples through the block, predicts the block means and their
// RMS about their mean at each waveform end, and compares each result field by
// field. A short directed table is followed by randomized waveforms over many
// block lengths, with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_decimated_waveform_rms;

  localparam int MAX_BLOCKS     = 1024;
  localparam int SAMPLE_BITS    = 16;
  localparam int RANDOM_ITEMS   = 750;
  localparam int OVF_SAMPLES    = MAX_BLOCKS + 6;
  localparam int FILL_SAMPLES   = 24;
  localparam int SETTLE_CYCLES  = 400;
  localparam int RX_HOLD_CYCLES = 1500;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int N_DIR          = 21;

  typedef struct packed {
    logic [dwr_pkg::RMS_W-1:0]     rms;
    logic [dwr_pkg::CNT_OUT_W-1:0] blocks;
    logic                          no_blocks;
    logic                          overflow;
  } rms_result_t;

  // One row of the directed table. When wr is set, block_length is written
  // first. When typed is set, the listed result replaces the predicted one.
  typedef struct {
    bit                            wr;
    logic [dwr_pkg::LEN_W-1:0]     len;
    logic [SAMPLE_BITS-1:0]        smp;
    bit                            last;
    bit                            typed;
    logic [dwr_pkg::RMS_W-1:0]     rms;
    logic [dwr_pkg::CNT_OUT_W-1:0] blocks;
    bit                            nb;
    bit                            ovf;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    '{1'b0, 7'd0,   16'h0000, 1'b1, 1'b1, 23'd0, 11'd0, 1'b1, 1'b0},
    '{1'b1, 7'd1,   16'h7FFF, 1'b1, 1'b1, 23'd0, 11'd1, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'h8000, 1'b1, 1'b1, 23'd0, 11'd1, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'h7FFF, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'h8000, 1'b1, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b1, 7'd0,   16'h0064, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'hFF9C, 1'b1, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b1, 7'd127, 16'h0005, 1'b1, 1'b1, 23'd0, 11'd0, 1'b1, 1'b0},
    '{1'b1, 7'd2,   16'h0001, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'h0002, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'h0003, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'h0004, 1'b1, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b1, 7'd5,   16'h0007, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'h0008, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'h0009, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b1, 7'd2,   16'h000A, 1'b1, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b1, 7'd64,  16'hFFFF, 1'b1, 1'b1, 23'd0, 11'd0, 1'b1, 1'b0},
    '{1'b1, 7'd1,   16'h0001, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'hFFFE, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'h5555, 1'b0, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   16'hAAAA, 1'b1, 1'b0, 23'd0, 11'd0, 1'b0, 1'b0}
  };

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we      = 1'b0;
  logic [dwr_pkg::LEN_W-1:0]     cfg_wdata   = '0;
  logic                          s_tvalid    = 1'b0;
  logic                          s_tready;
  logic [SAMPLE_BITS-1:0]        s_tdata     = '0;
  logic                          s_tlast     = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready    = 1'b0;
  logic [dwr_pkg::OUT_TDATA_W-1:0] m_tdata;
  dwr_pkg::dwr_flags_t           m_tuser;

  // Predictor state.
  logic [dwr_pkg::LEN_W-1:0] wave_len = dwr_pkg::RESET_LEN;
  longint                    blk_acc;
  int                        blk_pos;
  int                        blk_count;
  longint                    mean_sum;
  logic [63:0]               sq_sum;
  bit                        ovf_seen;

  rms_result_t pending_rms_results [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int cycle_count    = 0;
  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int hold_seq       = 0;

  decimated_waveform_rms #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_decimated_waveform_rms failed");
    $finish;
  end

  function automatic int effective_len(input logic [dwr_pkg::LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > dwr_pkg::MAX_LEN) return int'(dwr_pkg::MAX_LEN);
    return int'(len);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void clear_waveform();
    blk_acc   = 0;
    blk_pos   = 0;
    blk_count = 0;
    mean_sum  = 0;
    sq_sum    = '0;
    ovf_seen  = 1'b0;
  endfunction

  // Takes one sample into the running block statistics. Returns 1 with the
  // expected result when the sample closes a waveform.
  function automatic bit predict_sample(input logic [SAMPLE_BITS-1:0] smp, input bit last,
                                        output rms_result_t res);
    longint       s;
    longint       mag;
    longint       q;
    int           eff;
    logic [127:0] a_term;
    logic [127:0] b_term;
    logic [127:0] quo;
    logic [63:0]  m1;
    logic [63:0]  variance;
    logic [63:0]  root;
    res = '0;
    s   = longint'($signed(smp));
    eff = effective_len(wave_len);
    blk_acc += s;
    blk_pos++;
    // A shorter length written mid-block closes the block on the next sample.
    if (blk_pos >= eff) begin
      mag = (blk_acc < 0) ? -blk_acc : blk_acc;
      q   = (mag * 256) / eff;
      if (blk_count >= MAX_BLOCKS) begin
        ovf_seen = 1'b1;
      end else begin
        blk_count++;
        mean_sum += (blk_acc < 0) ? -q : q;
        sq_sum   += 64'(q * q);
      end
      blk_acc = 0;
      blk_pos = 0;
    end
    if (!last) return 1'b0;
    if (blk_count != 0) begin
      m1     = (mean_sum < 0) ? 64'(-mean_sum) : 64'(mean_sum);
      a_term = 128'(blk_count) * 128'(sq_sum);
      b_term = 128'(m1) * 128'(m1);
      if (a_term > b_term) begin
        quo      = (a_term - b_term) / (128'(blk_count) * 128'(blk_count));
        variance = (quo[127:64] != 0) ? '1 : quo[63:0];
        root     = int_sqrt(variance);
        res.rms  = (root > 64'(dwr_pkg::RMS_MAX)) ? dwr_pkg::RMS_MAX : root[22:0];
      end
    end
    res.blocks    = blk_count[10:0];
    res.no_blocks = (blk_count == 0);
    res.overflow  = ovf_seen;
    clear_waveform();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Offers one sample and waits for the transaction. Called at a clock edge.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input bit last,
                             input bit typed, input rms_result_t typed_res);
    rms_result_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
    if (predict_sample(smp, last, res)) begin
      pending_rms_results = {pending_rms_results, (typed ? typed_res : res)};
    end
  endtask

  // Drops the input stream, lets every result and any block still in flight
  // drain out, then writes block_length.
  task automatic apply_block_length(input logic [dwr_pkg::LEN_W-1:0] len);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_rms_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    wave_len  = len;
  endtask

  task automatic set_idling(input int tx, input int rx);
    tx_idle_pct  = tx;
    rx_idle_pct <= rx;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int style,
                                                         input logic [SAMPLE_BITS-1:0] base);
    int v;
    case (style)
      0: return SAMPLE_BITS'($urandom());
      1: begin
        v = int'($urandom_range(0, 600)) - 300;
        return v[SAMPLE_BITS-1:0];
      end
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return base + SAMPLE_BITS'($urandom_range(0, 3));
    endcase
  endfunction

  // One waveform: a few whole blocks, sometimes a trailing partial block.
  task automatic send_waveform();
    int eff;
    int nblk;
    int rem;
    int total;
    int style;
    logic [SAMPLE_BITS-1:0] base;
    eff   = effective_len(wave_len);
    nblk  = $urandom_range(0, (eff >= 32) ? 2 : (eff >= 8) ? 4 : 8);
    rem   = (eff > 1 && $urandom_range(0, 99) < 35) ? $urandom_range(1, eff - 1) : 0;
    total = nblk * eff + rem;
    if (total == 0) total = 1;
    style = $urandom_range(0, 3);
    base  = SAMPLE_BITS'($urandom());
    for (int i = 0; i < total; i++) begin
      send_sample(pick_sample(style, base), i == total - 1, 1'b0, '0);
    end
  endtask

  // Output side: random idling, plus a long hold each time hold_seq moves.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    rms_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_rms_results.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_rms_results.pop_front();
        if (m_tdata[22:0] != want.rms)
          report_mismatch("rms_value", int'(m_tdata[22:0]), int'(want.rms));
        if (m_tdata[33:23] != want.blocks)
          report_mismatch("blocks_used", int'(m_tdata[33:23]), int'(want.blocks));
        if (m_tuser.no_blocks !== want.no_blocks)
          report_mismatch("no_blocks", int'(m_tuser.no_blocks), int'(want.no_blocks));
        if (m_tuser.block_overflow !== want.overflow)
          report_mismatch("block_overflow", int'(m_tuser.block_overflow), int'(want.overflow));
      end
    end
  end

  initial begin
    rms_result_t typed_res;
    int          len_plan [$];
    int          rand_base;
    int          items_rand;
    int          mode;
    int          new_mode;
    int          next_len;
    bit          hold_done;
    bit          ovf_done;
    len_plan  = '{1, 64, 0, 127, 3, 15, 8, 33};
    mode      = 0;
    hold_done = 1'b0;
    ovf_done  = 1'b0;
    clear_waveform();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling.
    set_idling(0, 0);
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].wr) apply_block_length(dir_rows[r].len);
      typed_res.rms       = dir_rows[r].rms;
      typed_res.blocks    = dir_rows[r].blocks;
      typed_res.no_blocks = dir_rows[r].nb;
      typed_res.overflow  = dir_rows[r].ovf;
      send_sample(dir_rows[r].smp, dir_rows[r].last, dir_rows[r].typed, typed_res);
    end

    // Random waveforms, one block length per phase.
    set_idling(18, 73);
    rand_base    = items_sent;
    items_rand   = 0;
    while (items_rand < RANDOM_ITEMS) begin
      new_mode = (items_rand * 3) / RANDOM_ITEMS;
      if (new_mode > 2) new_mode = 2;
      if (new_mode != mode) begin
        mode = new_mode;
        if (mode == 1) set_idling(73, 18);
        else set_idling(0, 0);
      end

      if (!ovf_done && items_rand >= RANDOM_ITEMS / 2) begin
        // More one-sample blocks than the block can hold in one waveform.
        apply_block_length(7'd1);
        for (int i = 0; i < OVF_SAMPLES; i++) begin
          send_sample(SAMPLE_BITS'($urandom()), i == OVF_SAMPLES - 1, 1'b0, '0);
        end
        ovf_done  = 1'b1;
        rand_base = rand_base + OVF_SAMPLES;
      end else begin
        if (mode == 2 && !hold_done) begin
          next_len = 2;
        end else if (len_plan.size() != 0) begin
          next_len = len_plan.pop_front();
        end else begin
          case ($urandom_range(0, 9))
            0: next_len = 0;
            1: next_len = $urandom_range(65, 127);
            2: next_len = 64;
            3, 4, 5: next_len = $urandom_range(1, 8);
            default: next_len = $urandom_range(1, 64);
          endcase
        end
        apply_block_length(next_len[dwr_pkg::LEN_W-1:0]);
        // Stall the output while short waveforms keep arriving, so the
        // result path and then the input queue back up.
        if (mode == 2 && !hold_done) begin
          hold_seq <= hold_seq + 1;
          hold_done = 1'b1;
          for (int i = 0; i < FILL_SAMPLES; i++) begin
            send_sample(SAMPLE_BITS'($urandom()), (i % 4) == 3, 1'b0, '0);
          end
        end
        repeat ($urandom_range(2, 5)) send_waveform();
        // Sometimes leave a block open across the next length change.
        if ($urandom_range(0, 99) < 40) begin
          repeat ($urandom_range(1, 5)) send_sample(SAMPLE_BITS'($urandom()), 1'b0, 1'b0, '0);
        end
      end
      items_rand = items_sent - rand_base;
    end

    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_rms_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_decimated_waveform_rms passed");
    end else begin
      $display("tb_decimated_waveform_rms failed");
    end
    $finish;
  end

endmodule
